@@ rtl/core/ptirq_pkg.sv @@
package ptirq_pkg;

    // Item operations
    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_READ   = 3'd1;
    localparam logic [2:0] OP_WRITE  = 3'd2;
    localparam logic [2:0] OP_CLEAR  = 3'd3;
    localparam logic [2:0] OP_VBLANK = 3'd4;
    localparam logic [2:0] OP_STAT   = 3'd5;

    // Register selectors
    localparam logic [2:0] SEL_DIVIDER = 3'd0;
    localparam logic [2:0] SEL_COUNTER = 3'd1;
    localparam logic [2:0] SEL_RELOAD  = 3'd2;
    localparam logic [2:0] SEL_MODE    = 3'd3;
    localparam logic [2:0] SEL_FLAGS   = 3'd4;
    localparam logic [2:0] SEL_ENABLE  = 3'd5;

    localparam logic [4:0] DIV_PERIOD      = 5'd16;
    localparam logic [4:0] IRQ_VBLANK_BIT  = 5'b00001;
    localparam logic [4:0] IRQ_STAT_BIT    = 5'b00010;
    localparam logic [4:0] IRQ_TIMER_BIT   = 5'b00100;
    localparam logic [7:0] IRQ_READ_ONES   = 8'hE0;
    localparam int         MODE_ENABLE_BIT = 2;

    localparam logic [6:0] PERIOD_64 = 7'd64;
    localparam logic [6:0] PERIOD_1  = 7'd1;
    localparam logic [6:0] PERIOD_4  = 7'd4;
    localparam logic [6:0] PERIOD_16 = 7'd16;

    typedef struct packed {
        logic [2:0] op;
        logic [2:0] reg_sel;
        logic [7:0] data;
    } ptirq_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [4:0] pending_irq;
        logic       timer_overflowed;
    } ptirq_result_t;

    function automatic logic [6:0] period_of(input logic [1:0] sel);
        logic [6:0] p;
        case (sel)
            2'd0:    p = PERIOD_64;
            2'd1:    p = PERIOD_1;
            2'd2:    p = PERIOD_4;
            default: p = PERIOD_16;
        endcase
        return p;
    endfunction

endpackage

@@ rtl/core/ptirq_if.sv @@
interface ptirq_cmd_if;
    import ptirq_pkg::*;

    logic       valid;
    logic       ready;
    logic [2:0] op;
    logic [2:0] reg_sel;
    logic [7:0] data;

    modport source (output valid, output op, output reg_sel, output data, input ready);
    modport sink   (input valid, input op, input reg_sel, input data, output ready);
endinterface

interface ptirq_rsp_if;
    import ptirq_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic [4:0] pending_irq;
    logic       timer_overflowed;

    modport source (output valid, output read_data, output pending_irq,
                    output timer_overflowed, input ready);
    modport sink   (input valid, input read_data, input pending_irq,
                    input timer_overflowed, output ready);
endinterface

@@ rtl/core/prescaled_timer_with_irq_flags_top.sv @@
// Timer and interrupt flag unit.
//
// Beats arrive on cmd: op, reg_sel and data. Each beat is a tick, a register
// read or write, a flag clear, a raise of the vblank or stat request, or a no-op.
// Every cmd beat produces exactly one rsp beat carrying read_data,
// pending_irq (enable mask AND request flags after the beat) and
// timer_overflowed.
//
// A cmd beat is captured in an input register; once the output register is free
// or being emptied, the timer state is updated and the result lands in the output
// register, from which it is offered on rsp. One beat is accepted every cycle
// for as long as rsp keeps taking results. The single input-to-output pass
// through the timer logic sets that figure.
//
// When rsp stalls, the output register holds its result and the input
// register holds one more beat; cmd.ready falls only once both are full.
// Reset clears the timer state to its power-on values (divider and counter
// at zero, counter disabled, period 64, no requests) and empties both stages.
module prescaled_timer_with_irq_flags_top (
    input  logic  clk,
    input  logic  rst_n,
    ptirq_cmd_if.sink   cmd,
    ptirq_rsp_if.source rsp
);
    import ptirq_pkg::*;

    logic          in_valid_reg,  in_valid_next;
    logic          out_valid_reg, out_valid_next;
    ptirq_item_t   in_item_reg;
    ptirq_result_t out_result_reg;
    ptirq_result_t step_result;
    logic          advance;
    logic          load_in;

    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign cmd.ready = !in_valid_reg || advance;
    assign load_in   = cmd.valid && cmd.ready;

    assign in_valid_next  = load_in ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);

    ptirq_timer u_timer (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (in_item_reg),
        .result (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            in_item_reg.op      <= cmd.op;
            in_item_reg.reg_sel <= cmd.reg_sel;
            in_item_reg.data    <= cmd.data;
        end
        if (advance)
        begin
            out_result_reg <= step_result;
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.read_data        = out_result_reg.read_data;
    assign rsp.pending_irq      = out_result_reg.pending_irq;
    assign rsp.timer_overflowed = out_result_reg.timer_overflowed;

endmodule

@@ rtl/core/ptirq_timer.sv @@
module ptirq_timer (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     fire,
    input  ptirq_pkg::ptirq_item_t   item,
    output ptirq_pkg::ptirq_result_t result
);
    import ptirq_pkg::*;

    logic [7:0] div_value_reg,   div_value_next;
    logic [4:0] div_pre_reg,     div_pre_next;
    logic [7:0] cnt_value_reg,   cnt_value_next;
    logic [7:0] reload_reg,      reload_next;
    logic [7:0] mode_reg,        mode_next;
    logic       cnt_en_reg,      cnt_en_next;
    logic [6:0] period_reg,      period_next;
    logic [7:0] cnt_pre_reg,     cnt_pre_next;
    logic [4:0] flags_reg,       flags_next;
    logic [4:0] enable_reg,      enable_next;

    logic [7:0] cnt_inc;
    logic [7:0] rd;
    logic       ovf;

    assign cnt_inc = cnt_value_reg + 8'd1;

    always_comb
    begin
        div_value_next = div_value_reg;
        div_pre_next   = div_pre_reg;
        cnt_value_next = cnt_value_reg;
        reload_next    = reload_reg;
        mode_next      = mode_reg;
        cnt_en_next    = cnt_en_reg;
        period_next    = period_reg;
        cnt_pre_next   = cnt_pre_reg;
        flags_next     = flags_reg;
        enable_next    = enable_reg;
        rd             = 8'd0;
        ovf            = 1'b0;

        case (item.op)
            OP_TICK:
            begin
                if (div_pre_reg == DIV_PERIOD)
                begin
                    div_value_next = div_value_reg + 8'd1;
                    div_pre_next   = 5'd1;
                end
                else
                begin
                    div_pre_next = div_pre_reg + 5'd1;
                end
                if (cnt_en_reg)
                begin
                    // The prescaler wraps through zero when the period has shrunk below it.
                    if (cnt_pre_reg == {1'b0, period_reg})
                    begin
                        cnt_pre_next = 8'd1;
                        if (cnt_inc == 8'd0)
                        begin
                            cnt_value_next = reload_reg;
                            flags_next     = flags_reg | IRQ_TIMER_BIT;
                            ovf            = 1'b1;
                        end
                        else
                        begin
                            cnt_value_next = cnt_inc;
                        end
                    end
                    else
                    begin
                        cnt_pre_next = cnt_pre_reg + 8'd1;
                    end
                end
            end
            OP_READ:
            begin
                case (item.reg_sel)
                    SEL_DIVIDER: rd = div_value_reg;
                    SEL_COUNTER: rd = cnt_value_reg;
                    SEL_RELOAD:  rd = reload_reg;
                    SEL_MODE:    rd = mode_reg;
                    SEL_FLAGS:   rd = IRQ_READ_ONES | {3'd0, flags_reg};
                    SEL_ENABLE:  rd = IRQ_READ_ONES | {3'd0, enable_reg};
                    default:     rd = 8'd0;
                endcase
            end
            OP_WRITE:
            begin
                case (item.reg_sel)
                    SEL_DIVIDER: div_value_next = 8'd0;
                    SEL_COUNTER: cnt_value_next = item.data;
                    SEL_RELOAD:  reload_next    = item.data;
                    SEL_MODE:
                    begin
                        mode_next   = item.data;
                        cnt_en_next = item.data[MODE_ENABLE_BIT];
                        period_next = period_of(item.data[1:0]);
                    end
                    SEL_FLAGS:   flags_next  = item.data[4:0];
                    SEL_ENABLE:  enable_next = item.data[4:0];
                    default:     ;
                endcase
            end
            OP_CLEAR:  flags_next = flags_reg & ~item.data[4:0];
            OP_VBLANK: flags_next = flags_reg | IRQ_VBLANK_BIT;
            OP_STAT:   flags_next = flags_reg | IRQ_STAT_BIT;
            default:   ;
        endcase
    end

    assign result.read_data        = rd;
    assign result.pending_irq      = enable_next & flags_next;
    assign result.timer_overflowed = ovf;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_value_reg <= 8'd0;
            div_pre_reg   <= 5'd1;
            cnt_value_reg <= 8'd0;
            reload_reg    <= 8'd0;
            mode_reg      <= 8'd0;
            cnt_en_reg    <= 1'b0;
            period_reg    <= PERIOD_64;
            cnt_pre_reg   <= 8'd1;
            flags_reg     <= 5'd0;
            enable_reg    <= 5'd0;
        end
        else if (fire)
        begin
            div_value_reg <= div_value_next;
            div_pre_reg   <= div_pre_next;
            cnt_value_reg <= cnt_value_next;
            reload_reg    <= reload_next;
            mode_reg      <= mode_next;
            cnt_en_reg    <= cnt_en_next;
            period_reg    <= period_next;
            cnt_pre_reg   <= cnt_pre_next;
            flags_reg     <= flags_next;
            enable_reg    <= enable_next;
        end
    end

endmodule

@@ verif/prescaled_timer_with_irq_flags_top_tb.sv @@
module prescaled_timer_with_irq_flags_top_tb;
    import ptirq_pkg::*;

    // Operation and selector codes that the block treats as no-ops.
    localparam logic [2:0] OP_SPARE_LO  = 3'd6;
    localparam logic [2:0] OP_SPARE_HI  = 3'd7;
    localparam logic [2:0] SEL_SPARE_LO = 3'd6;
    localparam logic [2:0] SEL_SPARE_HI = 3'd7;

    // Period selector codes held in the low bits of the mode byte.
    localparam logic [1:0] MODE_P64 = 2'd0;
    localparam logic [1:0] MODE_P1  = 2'd1;
    localparam logic [1:0] MODE_P4  = 2'd2;
    localparam logic [1:0] MODE_P16 = 2'd3;
    localparam logic [7:0] MODE_RUN = 8'(1) << MODE_ENABLE_BIT;

    localparam int RANDOM_BEATS = 1000;
    localparam int CALM_BEATS   = 150;
    localparam int QUIET_LIMIT  = 2000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [2:0] op;
        logic [2:0] sel;
        logic [7:0] data;
        logic       drain;
        logic       known;
        logic [7:0] rd;
        logic [4:0] pend;
        logic       ovf;
    } stim_row_t;

    logic clk;
    logic rst_n;

    ptirq_cmd_if cmd_bus ();
    ptirq_rsp_if rsp_bus ();

    prescaled_timer_with_irq_flags_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .rsp   (rsp_bus)
    );

    // Opening rows: after-reset reads, unused codes, flag handling, a counter wrap
    // from the top of its range, divider and unused-selector writes, a stopped counter.
    stim_row_t opening_rows [25] = '{
        '{OP_READ,     SEL_DIVIDER,  8'h00, 1'b0, 1'b1, 8'h00, 5'h00, 1'b0},
        '{OP_READ,     SEL_COUNTER,  8'hFF, 1'b0, 1'b1, 8'h00, 5'h00, 1'b0},
        '{OP_READ,     SEL_MODE,     8'h00, 1'b0, 1'b1, 8'h00, 5'h00, 1'b0},
        '{OP_READ,     SEL_FLAGS,    8'h00, 1'b0, 1'b1, 8'hE0, 5'h00, 1'b0},
        '{OP_READ,     SEL_ENABLE,   8'hFF, 1'b0, 1'b1, 8'hE0, 5'h00, 1'b0},
        '{OP_READ,     SEL_SPARE_LO, 8'h00, 1'b0, 1'b1, 8'h00, 5'h00, 1'b0},
        '{OP_SPARE_LO, SEL_SPARE_HI, 8'hFF, 1'b0, 1'b1, 8'h00, 5'h00, 1'b0},
        '{OP_SPARE_HI, SEL_DIVIDER,  8'h00, 1'b0, 1'b1, 8'h00, 5'h00, 1'b0},
        '{OP_WRITE,    SEL_ENABLE,   8'hFF, 1'b0, 1'b1, 8'h00, 5'h00, 1'b0},
        '{OP_READ,     SEL_ENABLE,   8'h00, 1'b0, 1'b1, 8'hFF, 5'h00, 1'b0},
        '{OP_VBLANK,   SEL_DIVIDER,  8'h00, 1'b0, 1'b1, 8'h00, 5'h01, 1'b0},
        '{OP_STAT,     SEL_DIVIDER,  8'h00, 1'b0, 1'b1, 8'h00, 5'h03, 1'b0},
        '{OP_WRITE,    SEL_FLAGS,    8'hFF, 1'b0, 1'b1, 8'h00, 5'h1F, 1'b0},
        '{OP_READ,     SEL_FLAGS,    8'h00, 1'b0, 1'b1, 8'hFF, 5'h1F, 1'b0},
        '{OP_CLEAR,    SEL_DIVIDER,  8'hFF, 1'b0, 1'b1, 8'h00, 5'h00, 1'b0},
        '{OP_WRITE,    SEL_RELOAD,   8'hFF, 1'b0, 1'b0, 8'h00, 5'h00, 1'b0},
        '{OP_WRITE,    SEL_COUNTER,  8'hFE, 1'b0, 1'b0, 8'h00, 5'h00, 1'b0},
        '{OP_WRITE,    SEL_MODE,     8'hFD, 1'b0, 1'b0, 8'h00, 5'h00, 1'b0},
        '{OP_TICK,     SEL_DIVIDER,  8'h00, 1'b0, 1'b0, 8'h00, 5'h00, 1'b0},
        '{OP_TICK,     SEL_DIVIDER,  8'h00, 1'b0, 1'b0, 8'h00, 5'h00, 1'b0},
        '{OP_READ,     SEL_RELOAD,   8'h00, 1'b0, 1'b0, 8'h00, 5'h00, 1'b0},
        '{OP_WRITE,    SEL_DIVIDER,  8'h5A, 1'b0, 1'b0, 8'h00, 5'h00, 1'b0},
        '{OP_WRITE,    SEL_SPARE_HI, 8'hAA, 1'b0, 1'b0, 8'h00, 5'h00, 1'b0},
        '{OP_WRITE,    SEL_MODE,     8'h00, 1'b0, 1'b0, 8'h00, 5'h00, 1'b0},
        '{OP_TICK,     SEL_DIVIDER,  8'h00, 1'b0, 1'b0, 8'h00, 5'h00, 1'b0}
    };

    stim_row_t     beat_plan [$];
    ptirq_result_t awaited_results [$];
    logic          drain_next;
    logic          calm;
    int            mismatches;
    int            quiet_cycles;

    // Shadow of the timer state.
    logic [7:0] div_count;
    logic [4:0] div_phase;
    logic [7:0] tim_count;
    logic [7:0] tim_reload;
    logic [7:0] tim_mode;
    logic       tim_run;
    logic [6:0] tim_period;
    logic [7:0] tim_phase;
    logic [4:0] irq_req;
    logic [4:0] irq_en;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [6:0] mode_period(input logic [1:0] psel);
        logic [6:0] p;
        case (psel)
            MODE_P64: p = PERIOD_64;
            MODE_P1:  p = PERIOD_1;
            MODE_P4:  p = PERIOD_4;
            default:  p = PERIOD_16;
        endcase
        return p;
    endfunction

    function automatic ptirq_result_t timer_step(input logic [2:0] op, input logic [2:0] sel,
                                                 input logic [7:0] data);
        ptirq_result_t r;
        r = '0;
        case (op)
            OP_TICK:
            begin
                if (div_phase == DIV_PERIOD)
                begin
                    div_count = div_count + 8'd1;
                    div_phase = 5'd1;
                end
                else
                    div_phase = div_phase + 5'd1;
                if (tim_run)
                begin
                    // The phase is 8 bits wide, so after a period shrink it runs on
                    // through zero before it meets the new period again.
                    if (tim_phase == {1'b0, tim_period})
                    begin
                        tim_count = tim_count + 8'd1;
                        if (tim_count == 8'd0)
                        begin
                            tim_count = tim_reload;
                            irq_req = irq_req | IRQ_TIMER_BIT;
                            r.timer_overflowed = 1'b1;
                        end
                        tim_phase = 8'd1;
                    end
                    else
                        tim_phase = tim_phase + 8'd1;
                end
            end
            OP_READ:
                case (sel)
                    SEL_DIVIDER: r.read_data = div_count;
                    SEL_COUNTER: r.read_data = tim_count;
                    SEL_RELOAD:  r.read_data = tim_reload;
                    SEL_MODE:    r.read_data = tim_mode;
                    SEL_FLAGS:   r.read_data = {3'b000, irq_req} | IRQ_READ_ONES;
                    SEL_ENABLE:  r.read_data = {3'b000, irq_en} | IRQ_READ_ONES;
                    default:     r.read_data = 8'h00;
                endcase
            OP_WRITE:
                case (sel)
                    SEL_DIVIDER: div_count = 8'h00;
                    SEL_COUNTER: tim_count = data;
                    SEL_RELOAD:  tim_reload = data;
                    SEL_MODE:
                    begin
                        tim_mode = data;
                        tim_run = data[MODE_ENABLE_BIT];
                        tim_period = mode_period(data[1:0]);
                    end
                    SEL_FLAGS:   irq_req = data[4:0];
                    SEL_ENABLE:  irq_en = data[4:0];
                    default: ;
                endcase
            OP_CLEAR:  irq_req = irq_req & ~data[4:0];
            OP_VBLANK: irq_req = irq_req | IRQ_VBLANK_BIT;
            OP_STAT:   irq_req = irq_req | IRQ_STAT_BIT;
            default: ;
        endcase
        r.pending_irq = irq_en & irq_req;
        return r;
    endfunction

    task automatic plan_beat(input logic [2:0] op, input logic [2:0] sel, input logic [7:0] data);
        stim_row_t row;
        row = '0;
        row.op = op;
        row.sel = sel;
        row.data = data;
        row.drain = drain_next;
        drain_next = 1'b0;
        beat_plan.push_back(row);
    endtask

    task automatic plan_ticks(input int n);
        for (int k = 0; k < n; k++)
        begin
            // An occasional read keeps the divider and counter visible mid-run.
            if ($urandom_range(0, 11) == 0)
                plan_beat(OP_READ, 3'($urandom_range(SEL_DIVIDER, SEL_SPARE_HI)), 8'($urandom));
            else
                plan_beat(OP_TICK, 3'($urandom_range(0, 7)), 8'($urandom));
        end
    endtask

    function automatic logic [7:0] mode_byte(input logic run, input logic [1:0] psel);
        return (8'($urandom) & ~(MODE_RUN | 8'h03)) | (run ? MODE_RUN : 8'h00) | {6'd0, psel};
    endfunction

    task automatic plan_random_part();
        int   start_len;
        int   n;
        logic [2:0] op_pick;
        start_len = beat_plan.size();
        drain_next = 1'b1;
        // Long period first, then a shrink to a period of one while the prescaler
        // is well past it, so it must run round through zero.
        plan_beat(OP_WRITE, SEL_COUNTER, 8'($urandom_range(200, 255)));
        plan_beat(OP_WRITE, SEL_MODE, mode_byte(1'b1, MODE_P64));
        plan_ticks(40);
        plan_beat(OP_WRITE, SEL_MODE, mode_byte(1'b1, MODE_P1));
        plan_ticks(230);
        while (beat_plan.size() - start_len < RANDOM_BEATS)
        begin
            if ($urandom_range(0, 5) == 0)
                drain_next = 1'b1;
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    if ($urandom_range(0, 1) == 1)
                        plan_beat(OP_WRITE, SEL_RELOAD, 8'($urandom));
                    if ($urandom_range(0, 1) == 1)
                        plan_beat(OP_WRITE, SEL_COUNTER, 8'($urandom_range(230, 255)));
                    else
                        plan_beat(OP_WRITE, SEL_COUNTER, 8'($urandom));
                    plan_beat(OP_WRITE, SEL_MODE,
                              mode_byte($urandom_range(0, 4) != 0, 2'($urandom)));
                    plan_ticks($urandom_range(8, 60));
                end
                4, 5:
                begin
                    n = $urandom_range(6, 20);
                    for (int k = 0; k < n; k++)
                    begin
                        case ($urandom_range(0, 6))
                            0: plan_beat(OP_VBLANK, 3'($urandom), 8'($urandom));
                            1: plan_beat(OP_STAT, 3'($urandom), 8'($urandom));
                            2: plan_beat(OP_CLEAR, 3'($urandom), 8'($urandom));
                            3: plan_beat(OP_WRITE, SEL_FLAGS, 8'($urandom));
                            4: plan_beat(OP_WRITE, SEL_ENABLE, 8'($urandom));
                            5: plan_beat(OP_READ, SEL_FLAGS, 8'($urandom));
                            default: plan_beat(OP_READ, SEL_ENABLE, 8'($urandom));
                        endcase
                    end
                end
                6:
                begin
                    n = $urandom_range(4, 10);
                    for (int k = 0; k < n; k++)
                    begin
                        op_pick = ($urandom_range(0, 1) == 1) ? OP_WRITE : OP_READ;
                        plan_beat(op_pick, 3'($urandom_range(SEL_DIVIDER, SEL_SPARE_HI)),
                                  8'($urandom));
                    end
                end
                7:
                begin
                    n = $urandom_range(5, 15);
                    for (int k = 0; k < n; k++)
                        plan_beat(3'($urandom), 3'($urandom), 8'($urandom));
                end
                default:
                    plan_ticks($urandom_range(20, 80));
            endcase
        end
    endtask

    task automatic log_mismatch(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
    endtask

    // Sender: walks the plan, with bursts of idle cycles and one or more pauses
    // until every outstanding result has been returned.
    initial
    begin
        stim_row_t     row;
        ptirq_result_t want;
        int            gap_len;
        int            gap_odds;
        rst_n = 1'b0;
        clk = 1'b0;
        cmd_bus.valid = 1'b0;
        cmd_bus.op = OP_TICK;
        cmd_bus.reg_sel = SEL_DIVIDER;
        cmd_bus.data = 8'h00;
        calm = 1'b0;
        drain_next = 1'b0;
        mismatches = 0;
        gap_odds = 0;
        div_count = 8'h00;
        div_phase = 5'd1;
        tim_count = 8'h00;
        tim_reload = 8'h00;
        tim_mode = 8'h00;
        tim_run = 1'b0;
        tim_period = PERIOD_64;
        tim_phase = 8'd1;
        irq_req = 5'h00;
        irq_en = 5'h00;
        foreach (opening_rows[k])
            beat_plan.push_back(opening_rows[k]);
        plan_random_part();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < beat_plan.size(); i++)
        begin
            row = beat_plan[i];
            if (i >= beat_plan.size() - CALM_BEATS)
                calm = 1'b1;
            if (i % 64 == 0)
                case ($urandom_range(0, 2))
                    0: gap_odds = 0;
                    1: gap_odds = 3;
                    default: gap_odds = 10;
                endcase
            gap_len = 0;
            if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
                gap_len = $urandom_range(1, 18);
            if (gap_len != 0 || (row.drain && awaited_results.size() != 0))
            begin
                cmd_bus.valid <= 1'b0;
                repeat (gap_len) @(posedge clk);
                if (row.drain)
                    while (awaited_results.size() != 0)
                        @(posedge clk);
            end
            cmd_bus.valid <= 1'b1;
            cmd_bus.op <= row.op;
            cmd_bus.reg_sel <= row.sel;
            cmd_bus.data <= row.data;
            do
                @(posedge clk);
            while (!cmd_bus.ready);
            want = timer_step(row.op, row.sel, row.data);
            if (row.known)
            begin
                want.read_data = row.rd;
                want.pending_irq = row.pend;
                want.timer_overflowed = row.ovf;
            end
            awaited_results.push_back(want);
        end
        cmd_bus.valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Receiver: checks each returned beat and stalls in random bursts.
    initial
    begin
        ptirq_result_t want;
        int            stall_left;
        int            stall_odds;
        int            cycle_no;
        rsp_bus.ready = 1'b0;
        stall_left = 0;
        stall_odds = 0;
        cycle_no = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                if (awaited_results.size() == 0)
                    log_mismatch("unexpected result",
                                 0, {rsp_bus.read_data, rsp_bus.pending_irq,
                                     rsp_bus.timer_overflowed});
                else
                begin
                    want = awaited_results.pop_front();
                    if (rsp_bus.read_data !== want.read_data)
                        log_mismatch("read_data", want.read_data, rsp_bus.read_data);
                    if (rsp_bus.pending_irq !== want.pending_irq)
                        log_mismatch("pending_irq", want.pending_irq, rsp_bus.pending_irq);
                    if (rsp_bus.timer_overflowed !== want.timer_overflowed)
                        log_mismatch("timer_overflowed", want.timer_overflowed,
                                     rsp_bus.timer_overflowed);
                end
            end
            if (cycle_no % 128 == 0)
                case ($urandom_range(0, 2))
                    0: stall_odds = 0;
                    1: stall_odds = 4;
                    default: stall_odds = 12;
                endcase
            cycle_no++;
            if (stall_left > 0 && !calm)
            begin
                stall_left--;
                rsp_bus.ready <= 1'b0;
            end
            else if (!calm && stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
            begin
                stall_left = $urandom_range(1, 18) - 1;
                rsp_bus.ready <= 1'b0;
            end
            else
                rsp_bus.ready <= 1'b1;
        end
    end

    // Watchdog: ends the run if no beat moves on either side for too long.
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (cmd_bus.valid && cmd_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

endmodule
